// ===== sv/pwp_pkg.sv =====
// ----------------------------------------------------------------------------
// pwp_pkg: shared types and constants for the pixel-to-world projection unit
// Widths, register indexes, sequencer states and small fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pwp_pkg;

   localparam int PIXEL_BITS = 12;
   localparam int COEF_BITS  = 20;
   localparam int CFG_W      = 60;
   localparam int RATE_W     = 10;
   localparam int POS_W      = 32;
   localparam int QUAT_W     = 16;
   localparam int OPD_W      = 34;
   localparam int PROD_W     = 2 * OPD_W;
   localparam int NORM_W     = 33;
   localparam int QUOT_W     = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_QPROD  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_RATE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_OFFSET = 3'd5;

   localparam logic [RATE_W-1:0]       RATE_RESET = 10'd1;
   localparam logic signed [POS_W-1:0] HOFF_RESET = 32'sd29491;
   localparam logic signed [POS_W-1:0] ROT_ONE    = 32'sd1073741824;

   localparam logic [1:0] LAST_AXIS     = 2'd2;
   localparam logic [1:0] LAST_BODY_COL = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BODY  = 7'b0000010,
      ST_QUAT  = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_WORLD = 7'b0010000,
      ST_SPEED = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   function automatic logic signed [COEF_BITS-1:0] coef(input logic [CFG_W-1:0] r,
                                                        input logic [1:0] j);
      coef = r[j*COEF_BITS +: COEF_BITS];
   endfunction

   function automatic logic ovf32(input logic signed [PROD_W-1:0] x);
      ovf32 = (x > 68'sd2147483647) || (x < -68'sd2147483648);
   endfunction

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      if (x > 68'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (x < -68'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = POS_W'(x);
      end
   endfunction

   // quaternion component order: w x y z
   // products: ww xx yy zz xy wz xz wy yz wx
   function automatic logic [1:0] quat_sel_a(input logic [3:0] k);
      unique case (k)
         4'd0: quat_sel_a = 2'd0;
         4'd1: quat_sel_a = 2'd1;
         4'd2: quat_sel_a = 2'd2;
         4'd3: quat_sel_a = 2'd3;
         4'd4: quat_sel_a = 2'd1;
         4'd5: quat_sel_a = 2'd0;
         4'd6: quat_sel_a = 2'd1;
         4'd7: quat_sel_a = 2'd0;
         4'd8: quat_sel_a = 2'd2;
         default: quat_sel_a = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] quat_sel_b(input logic [3:0] k);
      unique case (k)
         4'd0: quat_sel_b = 2'd0;
         4'd1: quat_sel_b = 2'd1;
         4'd2: quat_sel_b = 2'd2;
         4'd3: quat_sel_b = 2'd3;
         4'd4: quat_sel_b = 2'd2;
         4'd5: quat_sel_b = 2'd3;
         4'd6: quat_sel_b = 2'd3;
         4'd7: quat_sel_b = 2'd2;
         4'd8: quat_sel_b = 2'd3;
         default: quat_sel_b = 2'd1;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== sv/pwp_div.sv =====
// ----------------------------------------------------------------------------
// pwp_div: rotation entry divider
// Rounded quotient (mag * 2^30 + den/2) / den, one restoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pwp_pkg::NORM_W-1:0]  mag,
   input  wire logic [pwp_pkg::NORM_W-1:0]  den,
   output logic                             done,
   output logic [pwp_pkg::QUOT_W-1:0]       quot
);
   import pwp_pkg::*;

   localparam int DVD_W = NORM_W + 30;

   logic                 busy_ff;
   logic                 done_ff;
   logic [4:0]           cnt_ff;
   logic [NORM_W-1:0]    den_ff;
   logic [NORM_W-1:0]    rem_ff;
   logic [NORM_W-1:0]    rem_in;
   logic [QUOT_W-1:0]    sh_ff;
   logic [QUOT_W-1:0]    sh_in;
   logic [DVD_W-1:0]     dvd;
   logic [NORM_W:0]      rem2;
   logic                 ge;

   // quotient stays below 2^31, so the top bits start as the partial remainder
   assign dvd  = {mag, 30'b0} + DVD_W'(den >> 1);
   assign rem2 = {rem_ff, sh_ff[QUOT_W-1]};
   assign ge   = rem2 >= {1'b0, den_ff};

   always_comb begin
      rem_in = ge ? NORM_W'(rem2 - {1'b0, den_ff}) : NORM_W'(rem2);
      sh_in  = {sh_ff[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= NORM_W'(dvd[DVD_W-1:QUOT_W]);
         sh_ff  <= dvd[QUOT_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
   end

   assign done = done_ff;
   assign quot = sh_ff;

endmodule

`default_nettype wire

// ===== sv/pixel_to_world_projection_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_to_world_projection_unit: pixel back-projection to world coordinates
// Body point from the projection matrix and depth, rotation by the normalized
// attitude quaternion, vehicle offset and velocity against the previous point.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   pixel, vehicle position, quat
//   rsp_      out        rsp_valid/rsp_ready   world point, speed, flags
//   csr_      in         csr_write_en          csr_index, csr_wdata
//
// Each item runs through a shared 34x34 multiplier, which does 34 products,
// and a 1-bit-per-cycle divider, which forms the nine rotation entries. A
// zero quaternion skips the divider. The next input is taken only once the
// unit is idle again. req_ready is high only when idle; the result holds on
// rsp_ until transferred. Reset restores register defaults and the zero point.
`default_nettype none

module pixel_to_world_projection_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [pwp_pkg::PIXEL_BITS-1:0]     req_pixel_u,
   input  wire logic [pwp_pkg::PIXEL_BITS-1:0]     req_pixel_v,
   input  wire logic signed [pwp_pkg::POS_W-1:0]   req_vehicle_x,
   input  wire logic signed [pwp_pkg::POS_W-1:0]   req_vehicle_y,
   input  wire logic signed [pwp_pkg::POS_W-1:0]   req_vehicle_z,
   input  wire logic signed [pwp_pkg::QUAT_W-1:0]  req_quat_w,
   input  wire logic signed [pwp_pkg::QUAT_W-1:0]  req_quat_x,
   input  wire logic signed [pwp_pkg::QUAT_W-1:0]  req_quat_y,
   input  wire logic signed [pwp_pkg::QUAT_W-1:0]  req_quat_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_world_x,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_world_y,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_world_z,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_speed_x,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_speed_y,
   output logic signed [pwp_pkg::POS_W-1:0]        rsp_speed_z,
   output logic                                    rsp_clipped,
   output logic                                    rsp_bad_attitude,
   input  wire logic                               csr_write_en,
   input  wire logic [pwp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pwp_pkg::CFG_W-1:0]          csr_wdata
);
   import pwp_pkg::*;

   // configuration
   logic [CFG_W-1:0]        proj_ff [0:2];
   logic [CFG_W-1:0]        mount_ff;
   logic [RATE_W-1:0]       rate_ff;
   logic signed [POS_W-1:0] hoff_ff;

   // sequencer
   state_type  state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic [3:0] idx_ff, idx_in;
   logic       ph_ff, ph_in;
   logic       dph_ff, dph_in;
   logic       div_start;
   logic       div_done;
   logic [QUOT_W-1:0] div_quot;

   // datapath
   logic [PIXEL_BITS-1:0]    u_ff, v_ff;
   logic signed [POS_W-1:0]  pos_ff   [0:2];
   logic signed [QUAT_W-1:0] quat_ff  [0:3];
   logic signed [POS_W:0]    s_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [34:0]       r_ff;
   logic signed [POS_W-1:0]  body_ff  [0:2];
   logic signed [POS_W-1:0]  pq_ff    [0:NUM_QPROD-1];
   logic signed [POS_W-1:0]  rot_ff   [0:2][0:2];
   logic signed [POS_W-1:0]  world_ff [0:2];
   logic signed [POS_W-1:0]  speed_ff [0:2];
   logic signed [POS_W-1:0]  last_ff  [0:2];
   logic                     clip_ff, bad_ff, neg_ff;

   logic signed [OPD_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] tb, bv, wsum, wrnd, wv;
   logic [NORM_W-1:0]        n2;
   logic signed [OPD_W-1:0]  n2s;
   logic signed [OPD_W-1:0]  m_sel;
   logic [NORM_W-1:0]        m_mag;
   logic signed [POS_W-1:0]  q32, rv;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff[0] <= '0;
         proj_ff[1] <= '0;
         proj_ff[2] <= '0;
         mount_ff   <= '0;
         rate_ff    <= RATE_RESET;
         hoff_ff    <= HOFF_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PROJ_ROW0:     proj_ff[0] <= csr_wdata;
            CSR_PROJ_ROW1:     proj_ff[1] <= csr_wdata;
            CSR_PROJ_ROW2:     proj_ff[2] <= csr_wdata;
            CSR_MOUNT_OFFSET:  mount_ff   <= csr_wdata;
            CSR_LOOP_RATE:     rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_HEIGHT_OFFSET: hoff_ff    <= signed'(csr_wdata[POS_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- divider
   pwp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (m_mag),
      .den   (n2),
      .done  (div_done),
      .quot  (div_quot)
   );

   // rotation numerators from the stored quaternion products
   always_comb begin
      n2 = NORM_W'(pq_ff[0][30:0]) + NORM_W'(pq_ff[1][30:0])
         + NORM_W'(pq_ff[2][30:0]) + NORM_W'(pq_ff[3][30:0]);
      n2s = signed'({1'b0, n2});
      unique case ({row_ff, col_ff})
         4'b0000: m_sel = n2s - 34'sd2 * (OPD_W'(pq_ff[2]) + OPD_W'(pq_ff[3]));
         4'b0001: m_sel = 34'sd2 * (OPD_W'(pq_ff[4]) - OPD_W'(pq_ff[5]));
         4'b0010: m_sel = 34'sd2 * (OPD_W'(pq_ff[6]) + OPD_W'(pq_ff[7]));
         4'b0100: m_sel = 34'sd2 * (OPD_W'(pq_ff[4]) + OPD_W'(pq_ff[5]));
         4'b0101: m_sel = n2s - 34'sd2 * (OPD_W'(pq_ff[1]) + OPD_W'(pq_ff[3]));
         4'b0110: m_sel = 34'sd2 * (OPD_W'(pq_ff[8]) - OPD_W'(pq_ff[9]));
         4'b1000: m_sel = 34'sd2 * (OPD_W'(pq_ff[6]) - OPD_W'(pq_ff[7]));
         4'b1001: m_sel = 34'sd2 * (OPD_W'(pq_ff[8]) + OPD_W'(pq_ff[9]));
         default: m_sel = n2s - 34'sd2 * (OPD_W'(pq_ff[1]) + OPD_W'(pq_ff[2]));
      endcase
      m_mag = m_sel[OPD_W-1] ? NORM_W'(-m_sel) : NORM_W'(m_sel);
      q32   = signed'(POS_W'(div_quot));
      rv    = neg_ff ? -q32 : q32;
   end

   // ---------------------------------------------------------------- multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_BODY: begin
            unique case (col_ff)
               2'd0: begin
                  mul_a = OPD_W'(coef(proj_ff[row_ff], 2'd0));
                  mul_b = signed'(OPD_W'(u_ff));
               end
               2'd1: begin
                  mul_a = OPD_W'(coef(proj_ff[row_ff], 2'd1));
                  mul_b = signed'(OPD_W'(v_ff));
               end
               2'd2: begin
                  mul_a = OPD_W'(s_ff);
                  mul_b = OPD_W'(signed'(r_ff[34:16]));
               end
               default: begin
                  mul_a = OPD_W'(s_ff);
                  mul_b = signed'(OPD_W'(r_ff[15:0]));
               end
            endcase
         end
         ST_QUAT: begin
            mul_a = OPD_W'(quat_ff[quat_sel_a(idx_ff)]);
            mul_b = OPD_W'(quat_ff[quat_sel_b(idx_ff)]);
         end
         ST_WORLD: begin
            mul_a = OPD_W'(rot_ff[row_ff][col_ff]);
            mul_b = OPD_W'(body_ff[col_ff]);
         end
         ST_SPEED: begin
            mul_a = OPD_W'(world_ff[row_ff]) - OPD_W'(last_ff[row_ff]);
            mul_b = signed'(OPD_W'(rate_ff));
         end
         default: ;
      endcase
   end

   always_comb begin
      tb   = (prod_ff + 68'sd32768) >>> 16;
      bv   = acc_ff + tb + PROD_W'(coef(mount_ff, row_ff));
      wsum = acc_ff + prod_ff;
      wrnd = (wsum + 68'sd536870912) >>> 30;
      wv   = wrnd + PROD_W'(pos_ff[row_ff]);
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      idx_in    = idx_ff;
      ph_in     = ph_ff;
      dph_in    = dph_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BODY;
               row_in   = '0;
               col_in   = '0;
               ph_in    = 1'b0;
            end
         end
         ST_BODY: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (col_ff == LAST_BODY_COL) begin
                  col_in = '0;
                  if (row_ff == LAST_AXIS) begin
                     row_in   = '0;
                     idx_in   = '0;
                     state_in = ST_QUAT;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         ST_QUAT: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (idx_ff == 4'(NUM_QPROD - 1)) begin
                  state_in = ST_DIV;
                  dph_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_DIV: begin
            if (!dph_ff) begin
               if (n2 == '0) begin
                  state_in = ST_WORLD;
                  ph_in    = 1'b0;
               end else begin
                  div_start = 1'b1;
                  dph_in    = 1'b1;
               end
            end else if (div_done) begin
               dph_in = 1'b0;
               if (col_ff == LAST_AXIS) begin
                  col_in = '0;
                  if (row_ff == LAST_AXIS) begin
                     row_in   = '0;
                     ph_in    = 1'b0;
                     state_in = ST_WORLD;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         ST_WORLD: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (col_ff == LAST_AXIS) begin
                  col_in = '0;
                  if (row_ff == LAST_AXIS) begin
                     row_in   = '0;
                     state_in = ST_SPEED;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         ST_SPEED: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (row_ff == LAST_AXIS) begin
                  state_in = ST_OUT;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         col_ff     <= '0;
         idx_ff     <= '0;
         ph_ff      <= 1'b0;
         dph_ff     <= 1'b0;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         last_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         idx_ff   <= idx_in;
         ph_ff    <= ph_in;
         dph_ff   <= dph_in;
         // the point becomes the reference once all speeds are formed
         if (state_ff == ST_SPEED && ph_ff && row_ff == LAST_AXIS) begin
            last_ff[0] <= world_ff[0];
            last_ff[1] <= world_ff[1];
            last_ff[2] <= world_ff[2];
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_valid && req_ready) begin
         u_ff       <= req_pixel_u;
         v_ff       <= req_pixel_v;
         pos_ff[0]  <= req_vehicle_x;
         pos_ff[1]  <= req_vehicle_y;
         pos_ff[2]  <= req_vehicle_z;
         quat_ff[0] <= req_quat_w;
         quat_ff[1] <= req_quat_x;
         quat_ff[2] <= req_quat_y;
         quat_ff[3] <= req_quat_z;
         s_ff       <= (POS_W+1)'(req_vehicle_z) - (POS_W+1)'(hoff_ff);
         clip_ff    <= 1'b0;
         bad_ff     <= 1'b0;
      end
      unique case (state_ff)
         ST_BODY: begin
            if (ph_ff) begin
               unique case (col_ff)
                  2'd0: acc_ff <= prod_ff + PROD_W'(coef(proj_ff[row_ff], 2'd2));
                  2'd1: r_ff   <= 35'(acc_ff + prod_ff);
                  2'd2: acc_ff <= prod_ff;
                  default: begin
                     body_ff[row_ff] <= sat32(bv);
                     clip_ff         <= clip_ff | ovf32(bv);
                  end
               endcase
            end
         end
         ST_QUAT: begin
            if (ph_ff) begin
               pq_ff[idx_ff] <= POS_W'(prod_ff);
            end
         end
         ST_DIV: begin
            if (!dph_ff) begin
               if (n2 == '0) begin
                  bad_ff <= 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     for (int j = 0; j < 3; j++) begin
                        rot_ff[i][j] <= (i == j) ? ROT_ONE : '0;
                     end
                  end
               end else begin
                  neg_ff <= m_sel[OPD_W-1];
               end
            end else if (div_done) begin
               rot_ff[row_ff][col_ff] <= rv;
            end
         end
         ST_WORLD: begin
            if (ph_ff) begin
               unique case (col_ff)
                  2'd0: acc_ff <= prod_ff;
                  2'd1: acc_ff <= wsum;
                  default: begin
                     world_ff[row_ff] <= sat32(wv);
                     clip_ff          <= clip_ff | ovf32(wv);
                  end
               endcase
            end
         end
         ST_SPEED: begin
            if (ph_ff) begin
               speed_ff[row_ff] <= sat32(prod_ff);
               clip_ff          <= clip_ff | ovf32(prod_ff);
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- ports
   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = state_ff == ST_OUT;
   assign rsp_world_x      = world_ff[0];
   assign rsp_world_y      = world_ff[1];
   assign rsp_world_z      = world_ff[2];
   assign rsp_speed_x      = speed_ff[0];
   assign rsp_speed_y      = speed_ff[1];
   assign rsp_speed_z      = speed_ff[2];
   assign rsp_clipped      = clip_ff;
   assign rsp_bad_attitude = bad_ff;

endmodule

`default_nettype wire
